FILE: src/uri_percent_decoder_assert.svh
// Assertion macros shared by the percent decoder modules.
`ifndef URI_PERCENT_DECODER_ASSERT_SVH
`define URI_PERCENT_DECODER_ASSERT_SVH
`ifndef SYNTH
// Checked while reset is released.
`define UPD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked at every edge, reset included.
`define UPD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define UPD_ASSERT(lbl, clk, rstn, prop, msg)
`define UPD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: src/upd_pkg.sv
// Types, constants and helper functions of the percent decoder.
package upd_pkg;

    localparam logic [7:0] PCT_CHAR = 8'h25;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam int         HEX_TEN  = 10;

    // Number of command entries between the front and the back.
    localparam int QDEPTH  = 2;
    localparam int PTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int COUNT_W = $clog2(QDEPTH + 1);

    // Most bytes that one input byte can release.
    localparam int MAX_OUT = 3;
    localparam int CNT_W   = $clog2(MAX_OUT + 1);
    localparam int IDX_W   = $clog2(MAX_OUT);

    typedef enum logic [1:0] {
        PEND_NONE  = 2'd0,
        PEND_PCT   = 2'd1,
        PEND_DIGIT = 2'd2
    } t_pend;

    typedef struct packed {
        logic       valid;
        logic       upper;
        logic [3:0] value;
    } t_hex;

    // One group of output bytes; last applies to the final byte of the group.
    typedef struct packed {
        logic [CNT_W-1:0]            cnt;
        logic                        last;
        logic [MAX_OUT-1:0][7:0]     bytes;
    } t_cmd;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h = '0;
        if (c >= CH_0 && c <= CH_9) begin
            h.valid = 1'b1;
            h.value = 4'(c - CH_0);
        end else if (c >= CH_LA && c <= CH_LF) begin
            h.valid = 1'b1;
            h.value = 4'(c - CH_LA) + 4'(HEX_TEN);
        end else if (c >= CH_UA && c <= CH_UF) begin
            h.valid = 1'b1;
            h.upper = 1'b1;
            h.value = 4'(c - CH_UA) + 4'(HEX_TEN);
        end
        return h;
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] v, input logic upper);
        logic [7:0] ch;
        if (v < 4'(HEX_TEN)) begin
            ch = CH_0 + {4'b0000, v};
        end else begin
            ch = (upper ? CH_UA : CH_LA) + {4'b0000, v - 4'(HEX_TEN)};
        end
        return ch;
    endfunction

endpackage

FILE: src/upd_in_if.sv
// Input channel carrying encoded text bytes.
interface upd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       end_of_text;

    modport source (output valid, output byte_in, output end_of_text, input ready);
    modport sink   (input valid, input byte_in, input end_of_text, output ready);
endinterface

FILE: src/upd_out_if.sv
// Output channel carrying decoded bytes.
interface upd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic       last_out;

    modport source (output valid, output byte_out, output last_out, input ready);
    modport sink   (input valid, input byte_out, input last_out, output ready);
endinterface

FILE: src/upd_front.sv
// Front end: classifies each input byte and groups the output bytes it releases.
module upd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    upd_in_if.sink        i_text,
    input  logic          i_q_ready,
    output logic          o_push,
    output upd_pkg::t_cmd o_cmd
);
    import upd_pkg::*;

    t_pend      r_pend;
    t_pend      n_pend;
    logic [3:0] r_nib;
    logic       r_upper;
    t_hex       hx;
    logic       accept;
    logic       idle_emits;
    logic       take_idle;
    logic       capture;
    logic [CNT_W-1:0] pre_cnt;
    logic [7:0] pre0;
    logic [7:0] pre1;

    assign hx         = hex_decode(i_text.byte_in);
    assign accept     = i_text.valid && i_q_ready;
    assign i_text.ready = i_q_ready;
    // A plain byte is passed on; a percent sign is held unless it ends the text.
    assign idle_emits = !(i_text.byte_in == PCT_CHAR && !i_text.end_of_text);
    assign capture    = (r_pend == PEND_PCT) && hx.valid && !i_text.end_of_text;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= PEND_NONE;
        end else if (accept) begin
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && capture) begin
            r_nib   <= hx.value;
            r_upper <= hx.upper;
        end
    end

    always_comb begin
        n_pend = idle_emits ? PEND_NONE : PEND_PCT;
        unique case (r_pend)
            PEND_PCT: begin
                if (hx.valid) begin
                    n_pend = i_text.end_of_text ? PEND_NONE : PEND_DIGIT;
                end
            end
            PEND_DIGIT: begin
                if (hx.valid) begin
                    n_pend = PEND_NONE;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.last = i_text.end_of_text;
        take_idle  = 1'b0;
        pre_cnt    = '0;
        pre0       = PCT_CHAR;
        pre1       = digit_char(r_nib, r_upper);
        unique case (r_pend)
            PEND_PCT: begin
                if (hx.valid) begin
                    if (i_text.end_of_text) begin
                        o_cmd.bytes[0] = PCT_CHAR;
                        o_cmd.bytes[1] = i_text.byte_in;
                        o_cmd.cnt      = CNT_W'(2);
                    end
                end else begin
                    pre_cnt   = CNT_W'(1);
                    take_idle = 1'b1;
                end
            end
            PEND_DIGIT: begin
                if (hx.valid) begin
                    o_cmd.bytes[0] = {r_nib, hx.value};
                    o_cmd.cnt      = CNT_W'(1);
                end else begin
                    pre_cnt   = CNT_W'(2);
                    take_idle = 1'b1;
                end
            end
            default: begin
                take_idle = 1'b1;
            end
        endcase
        if (take_idle) begin
            o_cmd.bytes[0]                 = pre0;
            o_cmd.bytes[1]                 = pre1;
            o_cmd.bytes[pre_cnt[IDX_W-1:0]] = i_text.byte_in;
            o_cmd.cnt                      = pre_cnt + CNT_W'(idle_emits);
        end
    end

    assign o_push = accept && (o_cmd.cnt != '0);

endmodule

FILE: src/upd_cmd_fifo.sv
// Short command queue between the front end and the output serializer.
module upd_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  upd_pkg::t_cmd i_cmd,
    output logic          o_ready,
    input  logic          i_pop,
    output logic          o_valid,
    output upd_pkg::t_cmd o_cmd
);
    import upd_pkg::*;

    `include "uri_percent_decoder_assert.svh"

    t_cmd               r_mem [QDEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [COUNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QDEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_ready = (r_count != COUNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + COUNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    `UPD_ASSERT(a_no_overflow, i_clk, i_rst_n, i_push |-> (r_count != COUNT_W'(QDEPTH)), "push into full queue")
    `UPD_ASSERT(a_no_underflow, i_clk, i_rst_n, i_pop |-> (r_count != '0), "pop from empty queue")
    `UPD_ASSERT(a_nonempty_cmd, i_clk, i_rst_n, i_push |-> (i_cmd.cnt != '0), "empty command queued")

endmodule

FILE: src/upd_back.sv
// Output serializer: sends the bytes of each queued command one per transaction.
module upd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  upd_pkg::t_cmd i_cmd,
    output logic          o_pop,
    upd_out_if.source     o_text
);
    import upd_pkg::*;

    `include "uri_percent_decoder_assert.svh"

    logic [IDX_W-1:0] r_idx;
    logic             at_end;
    logic             fire;

    assign at_end          = (CNT_W'(r_idx) == (i_cmd.cnt - CNT_W'(1)));
    assign fire            = i_valid && o_text.ready;
    assign o_pop           = fire && at_end;
    assign o_text.valid    = i_valid;
    assign o_text.byte_out = i_cmd.bytes[r_idx];
    assign o_text.last_out = i_cmd.last && at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (fire) begin
            r_idx <= at_end ? '0 : r_idx + IDX_W'(1);
        end
    end

    `UPD_ASSERT(a_idx_in_cmd, i_clk, i_rst_n, i_valid |-> (CNT_W'(r_idx) < i_cmd.cnt), "byte index past command")
    `UPD_ASSERT(a_idx_idle, i_clk, i_rst_n, !i_valid |-> (r_idx == '0), "byte index left over without a command")
    `UPD_ASSERT_ALWAYS(a_stall_hold, i_clk, (i_rst_n && i_valid && !o_text.ready) |=> (!i_rst_n || r_idx == $past(r_idx)), "byte index moved during stall")

endmodule

FILE: src/uri_percent_decoder.sv
// A decoded byte is registered in the queue when the input byte that completes it is
// accepted. Throughput: one input byte per cycle; a broken escape releases up to three
// bytes, which the output serializer drains at one byte per cycle while the receiver
// is ready, through a two-entry queue. Input is stalled only while that queue is full.
// Reset (synchronous, active low) clears the escape state and empties the queue.
// Held digit registers and queue entries are not cleared.
module uri_percent_decoder (
    input  logic      i_clk,
    input  logic      i_rst_n,
    upd_in_if.sink    i_text,
    upd_out_if.source o_text
);
    import upd_pkg::*;

    // The front end classifies every byte at once and writes the bytes it releases
    // as one command into the queue; an escape prefix releases nothing yet.
    logic q_ready;
    logic q_push;
    t_cmd q_in;

    // The queue head stays in place until the serializer has sent its last byte,
    // so the two sides stall independently of each other.
    logic q_valid;
    logic q_pop;
    t_cmd q_head;

    upd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_text    (i_text),
        .i_q_ready (q_ready),
        .o_push    (q_push),
        .o_cmd     (q_in)
    );

    upd_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_head)
    );

    // The serializer marks the end of the text on the final byte of the final command.
    upd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cmd   (q_head),
        .o_pop   (q_pop),
        .o_text  (o_text)
    );

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the streaming URI percent decoder.
`timescale 1ns / 1ps

module tb;
    import upd_pkg::*;

    // Decoded byte as seen on the output channel.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_dec_byte;

    // One row of the directed table. When typed is set, the first n bytes of dout
    // (highest byte first) are the literal expectation; the final one carries eot.
    typedef struct packed {
        logic [7:0]  din;
        logic        eot;
        logic        typed;
        logic [1:0]  n;
        logic [23:0] dout;
    } t_text_row;

    localparam int NUM_DIRECTED    = 25;
    localparam int RANDOM_ITEMS    = 405;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int DRAIN_CYCLES    = 10;
    localparam int LIMIT_CYCLES    = 50000;

    // Directed rows: extremes, clean escapes in both letter cases, broken escapes,
    // a '%' breaking an escape, escapes and pending bytes at the end of a string.
    localparam t_text_row DIRECTED [NUM_DIRECTED] = '{
        '{8'h00, 1'b0, 1'b1, 2'd1, 24'h000000},  // lowest byte, passed through
        '{8'hFF, 1'b1, 1'b1, 2'd1, 24'hFF0000},  // highest byte, ends a string
        '{8'h25, 1'b0, 1'b1, 2'd0, 24'h000000},  // '%' held
        '{8'h34, 1'b0, 1'b1, 2'd0, 24'h000000},  // '4' held
        '{8'h31, 1'b0, 1'b1, 2'd1, 24'h410000},  // "%41" decodes to 'A'
        '{8'h25, 1'b0, 1'b0, 2'd0, 24'h000000},  // '%'
        '{8'h66, 1'b0, 1'b0, 2'd0, 24'h000000},  // 'f'
        '{8'h46, 1'b1, 1'b1, 2'd1, 24'hFF0000},  // "%fF" at the very end
        '{8'h25, 1'b0, 1'b1, 2'd0, 24'h000000},  // '%'
        '{8'h47, 1'b0, 1'b1, 2'd2, 24'h254700},  // 'G' breaks the escape
        '{8'h25, 1'b0, 1'b1, 2'd0, 24'h000000},  // '%'
        '{8'h41, 1'b0, 1'b1, 2'd0, 24'h000000},  // 'A'
        '{8'h2B, 1'b0, 1'b1, 2'd3, 24'h25412B},  // '+' breaks it, stays a '+'
        '{8'h25, 1'b0, 1'b0, 2'd0, 24'h000000},  // '%'
        '{8'h62, 1'b0, 1'b0, 2'd0, 24'h000000},  // 'b'
        '{8'h25, 1'b0, 1'b0, 2'd0, 24'h000000},  // '%' breaks it and is held again
        '{8'h25, 1'b0, 1'b0, 2'd0, 24'h000000},  // second '%' in a row
        '{8'h30, 1'b0, 1'b0, 2'd0, 24'h000000},  // '0'
        '{8'h25, 1'b1, 1'b1, 2'd3, 24'h253025},  // '%' ends the string mid-escape
        '{8'h25, 1'b1, 1'b1, 2'd1, 24'h250000},  // lone '%' as the final byte
        '{8'h25, 1'b0, 1'b1, 2'd0, 24'h000000},  // '%'
        '{8'h61, 1'b1, 1'b1, 2'd2, 24'h256100},  // '%' plus digit at the end
        '{8'h25, 1'b0, 1'b1, 2'd0, 24'h000000},  // '%'
        '{8'h39, 1'b0, 1'b1, 2'd0, 24'h000000},  // '9'
        '{8'h00, 1'b1, 1'b1, 2'd3, 24'h253900}   // non-hex final byte breaks it
    };

    logic clk;
    logic rst_n;

    upd_in_if  text_in ();
    upd_out_if text_out ();

    uri_percent_decoder u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_text  (text_in),
        .o_text  (text_out)
    );

    // Decoder state mirrored by the predictor.
    t_pend      pend_st;
    logic [3:0] held_nib;
    logic       held_up;

    t_dec_byte step_out [$];   // bytes released by the byte just accepted
    t_dec_byte decoded_q [$];  // decoded bytes still to come out of the block

    // 0: sender idles 26 %, receiver 45 %; 1: the other way round; 2: no idling.
    int idle_mode;
    int hold_reqs;
    int hold_count;
    int error_count;
    int sent_count;
    int string_count;
    int checked_count;
    int cycle_count;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // A free-running cycle count bounds the run in case the block hangs.
    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d bytes outstanding",
                 cycle_count, decoded_q.size());
        $display("Test completed with failures");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t ns: %s mismatch: got %02h, expected %02h", $time, what, got, want);
        error_count++;
    endtask

    // Returns the value of a hex digit, or -1 when the byte is not one.
    function automatic int hex_of(input logic [7:0] c, output logic up);
        up = 1'b0;
        if (c >= CH_0 && c <= CH_9) begin
            return int'(c - CH_0);
        end
        if (c >= CH_LA && c <= CH_LF) begin
            return int'(c - CH_LA) + HEX_TEN;
        end
        if (c >= CH_UA && c <= CH_UF) begin
            up = 1'b1;
            return int'(c - CH_UA) + HEX_TEN;
        end
        return -1;
    endfunction

    // Character that spells a nibble, in the letter case given.
    function automatic logic [7:0] digit_of(input logic [3:0] v, input logic up);
        if (v < 4'(HEX_TEN)) begin
            return CH_0 + 8'(v);
        end
        return (up ? CH_UA : CH_LA) + 8'(v - 4'(HEX_TEN));
    endfunction

    function automatic void emit(input logic [7:0] b, input logic l);
        t_dec_byte d;
        d.data = b;
        d.last = l;
        step_out.push_back(d);
    endfunction

    // A byte handled with nothing pending: a '%' opens an escape unless it ends the string.
    function automatic void take_plain(input logic [7:0] b, input logic eot);
        if (b == PCT_CHAR && !eot) begin
            pend_st = PEND_PCT;
        end else begin
            emit(b, eot);
            pend_st = PEND_NONE;
        end
    endfunction

    function automatic void percent_decode(input logic [7:0] b, input logic eot);
        logic up;
        int   v;
        v = hex_of(b, up);
        case (pend_st)
            PEND_PCT: begin
                if (v < 0) begin
                    emit(PCT_CHAR, 1'b0);
                    take_plain(b, eot);
                end else if (eot) begin
                    // A lone digit at the end goes out literally behind its '%'.
                    emit(PCT_CHAR, 1'b0);
                    emit(b, 1'b1);
                    pend_st = PEND_NONE;
                end else begin
                    held_nib = v[3:0];
                    held_up  = up;
                    pend_st  = PEND_DIGIT;
                end
            end
            PEND_DIGIT: begin
                if (v >= 0) begin
                    emit({held_nib, v[3:0]}, eot);
                    pend_st = PEND_NONE;
                end else begin
                    // Broken after one digit: re-spell the digit in its original case.
                    emit(PCT_CHAR, 1'b0);
                    emit(digit_of(held_nib, held_up), 1'b0);
                    take_plain(b, eot);
                end
            end
            default: begin
                take_plain(b, eot);
            end
        endcase
    endfunction

    function automatic void commit_prediction();
        foreach (step_out[k]) begin
            decoded_q.push_back(step_out[k]);
        end
        step_out.delete();
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] c;
        logic       up;
        c = 8'($urandom_range(255));
        while (hex_of(c, up) >= 0) begin
            c = 8'($urandom_range(255));
        end
        return c;
    endfunction

    function automatic logic [7:0] random_digit();
        return digit_of(4'($urandom_range(15)), 1'($urandom_range(1)));
    endfunction

    // Offers one byte, idling first as the current mode asks, and returns in the
    // time step of the edge that accepts it.
    task automatic send_byte(input logic [7:0] b, input logic eot);
        int unsigned pct;
        pct = (idle_mode == 0) ? 26 : (idle_mode == 1) ? 45 : 0;
        while ($urandom_range(99) < pct) begin
            text_in.valid <= 1'b0;
            @(posedge clk);
        end
        text_in.valid       <= 1'b1;
        text_in.byte_in     <= b;
        text_in.end_of_text <= eot;
        do begin
            @(posedge clk);
        end while (text_in.ready !== 1'b1);
        sent_count++;
    endtask

    // Builds one string out of escapes, plain bytes and broken sequences, then sends it.
    task automatic send_random_string();
        logic [7:0] txt [$];
        int         ntok;
        int         kind;
        ntok = $urandom_range(1, 6);
        repeat (ntok) begin
            kind = $urandom_range(9);
            case (kind)
                0, 1, 2, 3: begin
                    txt.push_back(PCT_CHAR);
                    txt.push_back(random_digit());
                    txt.push_back(random_digit());
                end
                4, 5: begin
                    txt.push_back(8'($urandom_range(255)));
                end
                6: begin
                    txt.push_back(PCT_CHAR);
                    txt.push_back(non_hex_byte());
                end
                7: begin
                    txt.push_back(PCT_CHAR);
                    txt.push_back(random_digit());
                    txt.push_back(non_hex_byte());
                end
                8: begin
                    txt.push_back(PCT_CHAR);
                end
                default: begin
                    txt.push_back(PCT_CHAR);
                    txt.push_back(random_digit());
                end
            endcase
        end
        foreach (txt[k]) begin
            send_byte(txt[k], k == txt.size() - 1);
            percent_decode(txt[k], k == txt.size() - 1);
            commit_prediction();
        end
        string_count++;
    endtask

    task automatic check_decoded();
        t_dec_byte want;
        checked_count++;
        if (decoded_q.size() == 0) begin
            report_mismatch("unexpected output byte", text_out.byte_out, 8'h00);
        end else begin
            want = decoded_q.pop_front();
            if (text_out.byte_out !== want.data) begin
                report_mismatch("byte_out", text_out.byte_out, want.data);
            end
            if (text_out.last_out !== want.last) begin
                report_mismatch("last_out", 8'(text_out.last_out), 8'(want.last));
            end
        end
    endtask

    // Receiver: checks each transaction on the output, then decides ready for the next
    // cycle. A hold-off request keeps ready low long enough for the block to fill up.
    initial begin
        int unsigned pct;
        int          hold_left;
        int          hold_seen;
        hold_left = 0;
        hold_seen = 0;
        text_out.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n === 1'b1 && text_out.valid === 1'b1 && text_out.ready === 1'b1) begin
                check_decoded();
            end
            pct = (idle_mode == 0) ? 45 : (idle_mode == 1) ? 26 : 0;
            if (hold_seen != hold_reqs) begin
                hold_seen = hold_reqs;
                hold_left = HOLD_OFF_CYCLES;
                hold_count++;
            end
            if (hold_left > 0) begin
                hold_left--;
                text_out.ready <= 1'b0;
            end else begin
                text_out.ready <= ($urandom_range(99) >= pct);
            end
        end
    end

    initial begin
        t_text_row row;
        int        target;
        t_dec_byte d;
        idle_mode     = 0;
        hold_reqs     = 0;
        hold_count    = 0;
        error_count   = 0;
        sent_count    = 0;
        string_count  = 0;
        checked_count = 0;
        pend_st       = PEND_NONE;
        held_nib      = 4'h0;
        held_up       = 1'b0;
        rst_n               <= 1'b0;
        text_in.valid       <= 1'b0;
        text_in.byte_in     <= 8'h00;
        text_in.end_of_text <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: literal expectations where they are obvious, predictor elsewhere.
        for (int r = 0; r < NUM_DIRECTED; r++) begin
            row = DIRECTED[r];
            send_byte(row.din, row.eot);
            percent_decode(row.din, row.eot);
            if (row.typed) begin
                step_out.delete();
                for (int k = 0; k < int'(row.n); k++) begin
                    d.data = row.dout[23 - 8 * k -: 8];
                    d.last = row.eot && (k == int'(row.n) - 1);
                    decoded_q.push_back(d);
                end
            end else begin
                commit_prediction();
            end
        end
        string_count += 6;

        // Random part in three idling phases, each opened by a long output hold-off
        // while the sender keeps offering bytes.
        for (int phase = 0; phase < 3; phase++) begin
            idle_mode = phase;
            hold_reqs++;
            target = NUM_DIRECTED + (RANDOM_ITEMS * (phase + 1)) / 3;
            while (sent_count < target) begin
                send_random_string();
            end
        end
        text_in.valid <= 1'b0;

        while (decoded_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d encoded bytes in %0d strings and checked %0d decoded bytes.",
                 sent_count, string_count, checked_count);
        $display("Idling ran sender-heavy, receiver-heavy and off, with %0d long hold-offs.",
                 hold_count);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", error_count);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: uri_percent_decoder.f
+incdir+src
src/upd_pkg.sv
src/upd_in_if.sv
src/upd_out_if.sv
src/upd_front.sv
src/upd_cmd_fifo.sv
src/upd_back.sv
src/uri_percent_decoder.sv
dv/tb.sv
